// ===== sv/srhm_pkg.sv =====
`timescale 1ns / 1ps

package srhm_pkg;

	localparam int NOW_W      = 48;
	localparam int GAP_W      = 32;
	localparam int WLEN_W     = 7;
	localparam int THR_W      = 32;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;
	localparam int RATE_W     = 32;
	localparam int AGE_W      = 48;
	localparam int QUAL_W     = 2;
	localparam int S_TDATA_W  = 48;
	localparam int M_TDATA_W  = 88;

	localparam int                 SCALE_W    = 30;
	localparam logic [SCALE_W-1:0] RATE_SCALE = 30'd1_000_000_000;

	localparam logic [WLEN_W-1:0] WINDOW_LEN_RST    = 7'd30;
	localparam logic [THR_W-1:0]  STALE_TIMEOUT_RST = 32'd1_000_000;
	localparam logic [THR_W-1:0]  MIN_RATE_RST      = 32'd5_000;
	localparam logic [THR_W-1:0]  GOOD_RATE_RST     = 32'd15_000;
	localparam logic [THR_W-1:0]  EXC_RATE_RST      = 32'd28_000;

	localparam logic MODE_ARRIVAL = 1'b0;
	localparam logic MODE_QUERY   = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_WINDOW_LEN    = 3'd0,
		CFG_STALE_TIMEOUT = 3'd1,
		CFG_MIN_RATE      = 3'd2,
		CFG_GOOD_RATE     = 3'd3,
		CFG_EXC_RATE      = 3'd4
	} cfg_idx_t;

	typedef enum logic [QUAL_W-1:0] {
		QUAL_BELOW = 2'd0,
		QUAL_MIN   = 2'd1,
		QUAL_GOOD  = 2'd2,
		QUAL_EXC   = 2'd3
	} qual_t;

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_GAP  = 7'b0000010,
		ST_SUM  = 7'b0000100,
		ST_MUL  = 7'b0001000,
		ST_DIV  = 7'b0010000,
		ST_FIN  = 7'b0100000,
		ST_OUT  = 7'b1000000
	} state_t;

	typedef struct packed {
		logic [2:0]        pad;
		logic              healthy;
		qual_t             quality;
		logic [AGE_W-1:0]  age_us;
		logic [RATE_W-1:0] rate_mhz;
		logic              stale;
		logic              seen;
	} result_t;

endpackage

// ===== sv/stream_rate_health_monitor_top.sv =====
`timescale 1ns / 1ps

// channel   | handshake          | payload
// ----------+--------------------+-------------------------------------------------
// input     | s_tvalid, s_tready | s_tdata: now_us[47:0]; s_tuser: mode
// result    | m_tvalid, m_tready | m_tdata: seen, stale, rate_mhz, age_us, quality,
//           |                    |          healthy, 3 zero bits
// config    | cfg_we             | cfg_index, cfg_data
//
// One item is in work at a time, from accept until its result is loaded at the output;
// the bit-serial rate divider makes one quotient bit a cycle.
// The gap ring sits in one RAM: read at accept, written back in ST_SUM when a gap is stored.
// Reset is asynchronous and needs no clearing pass; a window_len write clears the tracker.
// A result stalled at the output holds the next item in its final state, ST_OUT, only.

module stream_rate_health_monitor_top import srhm_pkg::*; #(
	parameter int MAX_WINDOW = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [S_TDATA_W-1:0]  s_tdata,   // now_us[47:0]
	input  logic                  s_tuser,   // mode
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [M_TDATA_W-1:0]  m_tdata,   // seen, stale, rate_mhz[31:0], age_us[47:0],
	                                         // quality[1:0], healthy, 3 zero bits
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int IDX_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
	localparam int CNT_W = $clog2(MAX_WINDOW + 1);
	localparam int CMP_W = (CNT_W > WLEN_W) ? CNT_W : WLEN_W;
	localparam int SUM_W = GAP_W + CNT_W;
	localparam int NUM_W = CNT_W + SCALE_W;
	localparam int BIT_W = $clog2(NUM_W + 1);
	localparam int QW_W  = (NUM_W > RATE_W) ? NUM_W : RATE_W + 1;

	state_t state_q;

	logic                  mode_q;
	logic [NOW_W-1:0]      now_q;

	logic [WLEN_W-1:0]     window_len_q;
	logic [THR_W-1:0]      stale_timeout_q;
	logic [THR_W-1:0]      min_rate_q;
	logic [THR_W-1:0]      good_rate_q;
	logic [THR_W-1:0]      exc_rate_q;

	logic                  seen_q;
	logic [NOW_W-1:0]      last_q;
	logic [IDX_W-1:0]      head_q;
	logic [CNT_W-1:0]      count_q;
	logic [SUM_W-1:0]      sum_q;

	logic                  store_q;
	logic [GAP_W-1:0]      gap_q;
	logic [GAP_W-1:0]      old_q;
	logic [NUM_W-1:0]      num_q;
	logic [SUM_W-1:0]      rem_q;
	logic [BIT_W-1:0]      bit_q;
	logic                  rate_zero_q;
	logic [AGE_W-1:0]      age_q;
	logic                  stale_q;
	logic [RATE_W-1:0]     rate_q;

	result_t               result_q;
	logic                  m_tvalid_q;

	logic [CMP_W-1:0]      wl_ext;
	logic [CMP_W-1:0]      len_cmp;
	logic [IDX_W-1:0]      h_eff;
	logic [CMP_W-1:0]      h_inc;
	logic [IDX_W-1:0]      head_next;
	logic                  win_full;
	logic [NOW_W-1:0]      diff;
	logic [SUM_W:0]        trial;
	logic                  trial_ge;
	logic [GAP_W-1:0]      rd_data;
	logic                  mem_we;
	logic                  in_beat;
	logic                  out_load;
	qual_t                 quality;

	assign s_tready = (state_q == ST_IDLE);
	assign in_beat  = s_tvalid && s_tready;
	assign out_load = (state_q == ST_OUT) && (!m_tvalid_q || m_tready);

	always_comb begin
		wl_ext = CMP_W'(window_len_q);
		if (wl_ext == '0) begin
			len_cmp = CMP_W'(1);
		end else if (wl_ext > CMP_W'(MAX_WINDOW)) begin
			len_cmp = CMP_W'(MAX_WINDOW);
		end else begin
			len_cmp = wl_ext;
		end
		h_eff     = (CMP_W'(head_q) >= len_cmp) ? '0 : head_q;
		h_inc     = CMP_W'(h_eff) + CMP_W'(1);
		head_next = (h_inc >= len_cmp) ? '0 : IDX_W'(h_inc);
		win_full  = (CMP_W'(count_q) >= len_cmp);
		diff      = now_q - last_q;
		trial     = {rem_q, num_q[NUM_W-1]};
		trial_ge  = (trial >= {1'b0, sum_q});
	end

	always_comb begin
		if (rate_q < min_rate_q) begin
			quality = QUAL_BELOW;
		end else if (rate_q < good_rate_q) begin
			quality = QUAL_MIN;
		end else if (rate_q < exc_rate_q) begin
			quality = QUAL_GOOD;
		end else begin
			quality = QUAL_EXC;
		end
	end

	assign mem_we = (state_q == ST_SUM) && store_q;

	srhm_ram #(
		.WIDTH (GAP_W),
		.DEPTH (MAX_WINDOW)
	) gap_ram_i (
		.clk   (clk),
		.we    (mem_we),
		.waddr (h_eff),
		.wdata (gap_q),
		.raddr (h_eff),
		.rdata (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			window_len_q    <= WINDOW_LEN_RST;
			stale_timeout_q <= STALE_TIMEOUT_RST;
			min_rate_q      <= MIN_RATE_RST;
			good_rate_q     <= GOOD_RATE_RST;
			exc_rate_q      <= EXC_RATE_RST;
			seen_q          <= 1'b0;
			last_q          <= '0;
			head_q          <= '0;
			count_q         <= '0;
			sum_q           <= '0;
			bit_q           <= '0;
			m_tvalid_q      <= 1'b0;
		end else begin
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_beat) begin
						state_q <= ST_GAP;
					end
				end
				ST_GAP: begin
					state_q <= ST_SUM;
				end
				ST_SUM: begin
					if (store_q) begin
						sum_q  <= sum_q - (win_full ? SUM_W'(old_q) : '0) + SUM_W'(gap_q);
						head_q <= head_next;
						if (!win_full) begin
							count_q <= count_q + CNT_W'(1);
						end
					end
					if (mode_q == MODE_ARRIVAL) begin
						last_q <= now_q;
						seen_q <= 1'b1;
					end
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					bit_q   <= BIT_W'(NUM_W);
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					bit_q <= bit_q - BIT_W'(1);
					if (bit_q == BIT_W'(1)) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (cfg_we) begin
				case (cfg_idx_t'(cfg_index))
					CFG_WINDOW_LEN: begin
						window_len_q <= cfg_data[WLEN_W-1:0];
						seen_q       <= 1'b0;
						last_q       <= '0;
						head_q       <= '0;
						count_q      <= '0;
						sum_q        <= '0;
					end
					CFG_STALE_TIMEOUT: stale_timeout_q <= cfg_data;
					CFG_MIN_RATE:      min_rate_q      <= cfg_data;
					CFG_GOOD_RATE:     good_rate_q     <= cfg_data;
					CFG_EXC_RATE:      exc_rate_q      <= cfg_data;
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_beat) begin
			mode_q <= s_tuser;
			now_q  <= s_tdata[NOW_W-1:0];
		end
		if (state_q == ST_GAP) begin
			store_q <= (mode_q == MODE_ARRIVAL) && seen_q && (now_q > last_q);
			gap_q   <= (|diff[NOW_W-1:GAP_W]) ? '1 : diff[GAP_W-1:0];
			old_q   <= rd_data;
		end
		if (state_q == ST_MUL) begin
			num_q       <= NUM_W'(count_q) * NUM_W'(RATE_SCALE);
			rem_q       <= '0;
			rate_zero_q <= (count_q == '0) || (sum_q == '0);
			if (!seen_q) begin
				age_q <= '1;
			end else if (now_q > last_q) begin
				age_q <= diff;
			end else begin
				age_q <= '0;
			end
		end
		if (state_q == ST_DIV) begin
			rem_q <= trial_ge ? SUM_W'(trial - {1'b0, sum_q}) : trial[SUM_W-1:0];
			num_q <= {num_q[NUM_W-2:0], trial_ge};
		end
		if (state_q == ST_FIN) begin
			if (rate_zero_q) begin
				rate_q <= '0;
			end else if (QW_W'(num_q) > QW_W'({RATE_W{1'b1}})) begin
				rate_q <= '1;
			end else begin
				rate_q <= RATE_W'(num_q);
			end
			stale_q <= !seen_q || (age_q > AGE_W'(stale_timeout_q));
		end
		if (out_load) begin
			result_q.pad      <= '0;
			result_q.seen     <= seen_q;
			result_q.stale    <= stale_q;
			result_q.rate_mhz <= rate_q;
			result_q.age_us   <= age_q;
			result_q.quality  <= quality;
			result_q.healthy  <= seen_q && !stale_q && (quality != QUAL_BELOW);
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = result_q;

endmodule

// ===== sv/srhm_ram.sv =====
`timescale 1ns / 1ps

module srhm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                                       clk,
	input  logic                                       we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                           wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== sv/srhm_chk.sv =====
`timescale 1ns / 1ps

module srhm_chk import srhm_pkg::*; (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 s_tvalid,
	input logic                 s_tready,
	input logic                 m_tvalid,
	input logic                 m_tready,
	input logic [M_TDATA_W-1:0] m_tdata
);

	result_t res;

	assign res = result_t'(m_tdata);

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken while an item is still in work");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result beat changed");

	a_healthy: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> res.healthy == (res.seen && !res.stale && res.quality != QUAL_BELOW))
		else $error("healthy flag disagrees with seen, stale and quality");

	a_unseen: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !res.seen |-> res.stale && res.age_us == {AGE_W{1'b1}} &&
			res.rate_mhz == '0)
		else $error("unseen stream reports age, rate or freshness");

endmodule

bind stream_rate_health_monitor_top srhm_chk chk_i (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
